@@ design/binary_heap_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binary heap priority queue
// Shorthand for clocked implication checks with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared constants and codes of the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_VALUE_BITS = 32;

  localparam int OP_BITS        = 2;
  localparam int IN_VALUE_BITS  = 32;
  localparam int POS_BITS       = 9;
  localparam int STATUS_BITS    = 2;
  localparam int COUNT_OUT_BITS = 9;

  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_BAD_POS = 2'd3
  } status_t;

endpackage

@@ design/binary_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Min or max binary heap with insert, delete at position and peek commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result, shown for a single cycle with out_valid high, and the
// receiver cannot stall it, so it must take each result as it appears. The
// result always shows in the first cycle after the command in which busy is
// low again. Peek and every rejected command (insert when full, delete when
// empty, delete at position zero or beyond the count) leave busy low, so their
// result shows in the very next cycle. An insert holds busy while the new
// value climbs level by level towards the root and then while it is written
// into its slot; on an empty heap it is written at once. A delete holds busy
// while the ancestors of the deleted position shift down one level each, the
// former last entry is read, that entry sinks level by level from the root
// (with one more compare when it comes to rest while it still has a child),
// and it is written into its slot; a delete that empties the heap ends once
// the last entry has been read. Every step of a sift waits for one registered
// memory read. The store needs no clearing after reset: only the first count
// entries are ever used. max_mode may be written only while no command is in
// flight.
// ----------------------------------------------------------------------------
`include "binary_heap_priority_queue_macros.svh"

module binary_heap_priority_queue #(
  parameter int CAPACITY   = bhpq_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = bhpq_pkg::DEF_VALUE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic                                    cfg_wr_data,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [bhpq_pkg::OP_BITS-1:0]            in_op,
  input  logic signed [bhpq_pkg::IN_VALUE_BITS-1:0] in_value,
  input  logic [bhpq_pkg::POS_BITS-1:0]           in_position,
  output logic                                    out_valid,
  output logic [bhpq_pkg::STATUS_BITS-1:0]        out_status,
  output logic signed [bhpq_pkg::IN_VALUE_BITS-1:0] out_top_value,
  output logic                                    out_top_valid,
  output logic [bhpq_pkg::COUNT_OUT_BITS-1:0]     out_entry_count
);
  import bhpq_pkg::*;

  // Count holds 0..CAPACITY; heap indexes are 1-based and need one more bit
  // so that the left child of the last entry can be formed.
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = CW + 1;
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DEL_SHIFT,
    ST_DEL_LAST_RD,
    ST_DEL_LAST,
    ST_DOWN,
    ST_FILL
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [VALUE_BITS-1:0] hold_r, hold_nxt;
  logic [VALUE_BITS-1:0] root_r;
  logic                  max_mode_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [IN_VALUE_BITS-1:0] out_top_value_r;
  logic                  out_top_valid_r;
  logic [COUNT_OUT_BITS-1:0] out_entry_count_r;

  logic                  emit;
  status_t               emit_status;
  logic [VALUE_BITS-1:0] emit_top;

  logic [IW-1:0]         rd_a_idx, rd_b_idx, wr_idx;
  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_data;
  logic [VALUE_BITS-1:0] rd_a_data, rd_b_data;

  logic [IW-1:0]         parent_idx, left_idx, pick_idx, pick_child;
  logic                  right_ok, pick_right;
  logic [VALUE_BITS-1:0] pick_val;
  logic                  in_accept;

  // Strict ordering test for the current mode; equal values never move.
  function automatic logic better(input logic [VALUE_BITS-1:0] a,
                                  input logic [VALUE_BITS-1:0] b,
                                  input logic                  mx);
    return mx ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

  bhpq_ram #(
    .DEPTH      (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(wr_idx - IW'(1))),
    .wr_data   (wr_data),
    .rd_a_addr (AW'(rd_a_idx - IW'(1))),
    .rd_b_addr (AW'(rd_b_idx - IW'(1))),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  assign in_accept = start && (state_r == ST_IDLE);

  // Child selection for the sift-down step: the right child is used only
  // when it exists and is strictly better than the left one.
  assign parent_idx = idx_r >> 1;
  assign left_idx   = idx_r << 1;
  assign right_ok   = (left_idx + IW'(1)) <= IW'(count_r);
  assign pick_right = right_ok && better(rd_b_data, rd_a_data, max_mode_r);
  assign pick_val   = pick_right ? rd_b_data : rd_a_data;
  assign pick_idx   = pick_right ? (left_idx + IW'(1)) : left_idx;
  assign pick_child = pick_idx << 1;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    hold_nxt    = hold_r;
    rd_a_idx    = IW'(1);
    rd_b_idx    = IW'(1);
    wr_en       = 1'b0;
    wr_idx      = idx_r;
    wr_data     = hold_r;
    emit        = 1'b0;
    emit_status = STATUS_OK;
    emit_top    = root_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                emit        = 1'b1;
                emit_status = STATUS_FULL;
              end else begin
                // The new value waits in a register while the hole climbs.
                count_nxt = count_r + CW'(1);
                idx_nxt   = IW'(count_r) + IW'(1);
                hold_nxt  = VALUE_BITS'(in_value);
                if (count_r == '0) begin
                  state_nxt = ST_FILL;
                end else begin
                  rd_a_idx  = (IW'(count_r) + IW'(1)) >> 1;
                  state_nxt = ST_UP;
                end
              end
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                emit        = 1'b1;
                emit_status = STATUS_EMPTY;
              end else if ((in_position == '0) ||
                           (CMPW'(in_position) > CMPW'(count_r))) begin
                emit        = 1'b1;
                emit_status = STATUS_BAD_POS;
              end else begin
                idx_nxt = IW'(in_position);
                if (in_position > POS_BITS'(1)) begin
                  rd_a_idx  = IW'(in_position) >> 1;
                  state_nxt = ST_DEL_SHIFT;
                end else begin
                  state_nxt = ST_DEL_LAST_RD;
                end
              end
            end
            default: begin
              // Peek and the unused code only report the heap.
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_UP: begin
        if (better(hold_r, rd_a_data, max_mode_r)) begin
          wr_en   = 1'b1;
          wr_data = rd_a_data;
          idx_nxt = parent_idx;
          if (parent_idx > IW'(1)) begin
            rd_a_idx = parent_idx >> 1;
          end else begin
            state_nxt = ST_FILL;
          end
        end else begin
          state_nxt = ST_FILL;
        end
      end

      ST_DEL_SHIFT: begin
        // Each ancestor on the path moves down one level over the deleted entry.
        wr_en   = 1'b1;
        wr_data = rd_a_data;
        idx_nxt = parent_idx;
        if (parent_idx > IW'(1)) begin
          rd_a_idx = parent_idx >> 1;
        end else begin
          state_nxt = ST_DEL_LAST_RD;
        end
      end

      ST_DEL_LAST_RD: begin
        // Issued in the cycle after the last shift write, so the last entry is current.
        rd_a_idx  = IW'(count_r);
        state_nxt = ST_DEL_LAST;
      end

      ST_DEL_LAST: begin
        hold_nxt  = rd_a_data;
        count_nxt = count_r - CW'(1);
        idx_nxt   = IW'(1);
        if (count_r == CW'(1)) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end else if (count_r == CW'(2)) begin
          state_nxt = ST_FILL;
        end else begin
          rd_a_idx  = IW'(2);
          rd_b_idx  = IW'(3);
          state_nxt = ST_DOWN;
        end
      end

      ST_DOWN: begin
        if (better(pick_val, hold_r, max_mode_r)) begin
          wr_en   = 1'b1;
          wr_data = pick_val;
          idx_nxt = pick_idx;
          if (pick_child > IW'(count_r)) begin
            state_nxt = ST_FILL;
          end else begin
            rd_a_idx = pick_child;
            rd_b_idx = pick_child + IW'(1);
          end
        end else begin
          state_nxt = ST_FILL;
        end
      end

      ST_FILL: begin
        wr_en     = 1'b1;
        emit      = 1'b1;
        emit_top  = (idx_r == IW'(1)) ? hold_r : root_r;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      max_mode_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= emit;
      if (cfg_wr_en) begin
        max_mode_r <= cfg_wr_data;
      end
    end
    idx_r  <= idx_nxt;
    hold_r <= hold_nxt;
    // The root is mirrored in a register so that results need no extra read.
    if (wr_en && (wr_idx == IW'(1))) begin
      root_r <= wr_data;
    end
    if (emit) begin
      out_status_r      <= emit_status;
      out_top_valid_r   <= (count_nxt != '0);
      out_top_value_r   <= (count_nxt != '0) ? IN_VALUE_BITS'(emit_top) : '0;
      out_entry_count_r <= COUNT_OUT_BITS'(count_nxt);
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_top_value   = out_top_value_r;
  assign out_top_valid   = out_top_valid_r;
  assign out_entry_count = out_entry_count_r;

  `BHPQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `BHPQ_ASSERT_SAME(a_idle_no_write, clk, rst_n, state_r == ST_IDLE, !wr_en, "heap write while idle")
  `BHPQ_ASSERT_SAME(a_result_at_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE, "result while busy")
  `BHPQ_ASSERT_NEXT(a_accept_progress, clk, rst_n, in_accept, busy || out_valid_r, "command dropped")

endmodule

@@ design/bhpq_ram.sv @@
// ----------------------------------------------------------------------------
// bhpq_ram
// Heap storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int DEPTH      = bhpq_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = bhpq_pkg::DEF_VALUE_BITS,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  input  logic [AW-1:0]         rd_a_addr,
  input  logic [AW-1:0]         rd_b_addr,
  output logic [VALUE_BITS-1:0] rd_a_data,
  output logic [VALUE_BITS-1:0] rd_b_data
);
  import bhpq_pkg::*;

  logic [VALUE_BITS-1:0] mem [DEPTH];

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule
